// File: rtl/core/psu_pkg.sv
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, constants and the Paeth predictor for the scanline unfilter.
// ----------------------------------------------------------------------------
package psu_pkg;

    localparam int DEF_MAX_ROW_BYTES   = 8192;
    localparam int DEF_MAX_PIXEL_BYTES = 4;

    localparam int ROW_BYTES_W = 14;
    localparam int BPP_W       = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BPP       = 1'd1;

    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_SUB   = 3'd1,
        FLT_UP    = 3'd2,
        FLT_AVG   = 3'd3,
        FLT_PAETH = 3'd4
    } t_filter;

    // One item in the read stage, waiting on line store data.
    typedef struct packed {
        logic       is_data;
        logic [7:0] x;
        t_filter    filt;
        logic       a_en;
        logic       b_en;
        logic       last;
    } t_s1;

    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] dc;
        logic [9:0]        pa;
        logic [9:0]        pb;
        logic [9:0]        pc;
        da = $signed({2'b00, b}) - $signed({2'b00, c});
        db = $signed({2'b00, a}) - $signed({2'b00, c});
        dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
        pa = (da < 0) ? 10'(-da) : 10'(da);
        pb = (db < 0) ? 10'(-db) : 10'(db);
        pc = (dc < 0) ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end
        return c;
    endfunction

endpackage

// File: rtl/core/psu_line_mem.sv
// ----------------------------------------------------------------------------
// psu_line_mem
// Line store for the previous scanline: one write port, one registered read.
// ----------------------------------------------------------------------------
module psu_line_mem
    import psu_pkg::*;
#(
    parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
    parameter int ADDR_W        = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1
) (
    input  logic              i_clk,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata
);

    logic [7:0] r_mem [MAX_ROW_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/psu_seq.sv
// ----------------------------------------------------------------------------
// psu_seq
// Row sequencer: config registers, byte position, row filter, read stage.
// ----------------------------------------------------------------------------
module psu_seq
    import psu_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = DEF_MAX_ROW_BYTES,
    parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES,
    parameter int ADDR_W          = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1,
    parameter int SEL_W           = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_stream_byte,
    input  logic                  i_image_start,
    input  logic                  i_s1_adv,
    output logic                  o_s1_valid,
    output t_s1                   o_s1,
    output logic [ADDR_W-1:0]     o_s1_idx,
    output logic [SEL_W-1:0]      o_s1_sel,
    output logic                  o_rd_en,
    output logic [ADDR_W-1:0]     o_rd_addr
);

    localparam int POS_W = $clog2(MAX_ROW_BYTES + 1);
    localparam int RCW   = (POS_W > ROW_BYTES_W) ? POS_W : ROW_BYTES_W;
    localparam int BPW   = $clog2(MAX_PIXEL_BYTES + 1);
    localparam int BCW0  = (ADDR_W > BPW) ? ADDR_W : BPW;
    localparam int BCW   = (BCW0 > BPP_W) ? BCW0 : BPP_W;

    logic [ROW_BYTES_W-1:0] r_row_bytes;
    logic [BPP_W-1:0]       r_bpp;
    logic [POS_W-1:0]       r_pos,   n_pos;
    t_filter                r_filter, n_filter;
    logic                   r_first, n_first;
    logic                   r_s1_valid;
    t_s1                    r_s1,    n_s1;
    logic [ADDR_W-1:0]      r_s1_idx;
    logic [SEL_W-1:0]       r_s1_sel;

    logic [POS_W-1:0]  rb_eff;
    logic [BPW-1:0]    bpp_eff;
    logic              accept;
    logic              first;
    logic [POS_W-1:0]  pos;
    logic [ADDR_W-1:0] idx;

    // clamp the registers into their legal range
    always_comb begin
        if (r_row_bytes == '0) begin
            rb_eff = POS_W'(1);
        end else if (RCW'(r_row_bytes) > RCW'(MAX_ROW_BYTES)) begin
            rb_eff = POS_W'(MAX_ROW_BYTES);
        end else begin
            rb_eff = POS_W'(r_row_bytes);
        end
        if (r_bpp == '0) begin
            bpp_eff = BPW'(1);
        end else if (BCW'(r_bpp) > BCW'(MAX_PIXEL_BYTES)) begin
            bpp_eff = BPW'(MAX_PIXEL_BYTES);
        end else begin
            bpp_eff = BPW'(r_bpp);
        end
    end

    assign o_in_stall = r_s1_valid && !i_s1_adv;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        first    = i_image_start ? 1'b1 : r_first;
        pos      = i_image_start ? '0 : r_pos;
        idx      = ADDR_W'(pos - POS_W'(1));
        n_pos    = r_pos;
        n_filter = r_filter;
        n_first  = r_first;
        n_s1         = '0;
        n_s1.x       = i_stream_byte;
        n_s1.filt    = r_filter;
        n_s1.b_en    = !first;
        n_s1.a_en    = BCW'(idx) >= BCW'(bpp_eff);
        n_s1.last    = pos >= rb_eff;
        if (pos == '0) begin
            // filter byte: latch the rule, unknown codes act as None
            n_filter   = (i_stream_byte <= 8'd4) ? t_filter'(i_stream_byte[2:0]) : FLT_NONE;
            n_pos      = POS_W'(1);
            n_first    = first;
        end else begin
            n_s1.is_data = 1'b1;
            n_pos        = n_s1.last ? '0 : pos + POS_W'(1);
            n_first      = n_s1.last ? 1'b0 : first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes <= ROW_BYTES_W'(1);
            r_bpp       <= BPP_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROW_BYTES: r_row_bytes <= i_cfg_data[ROW_BYTES_W-1:0];
                CFG_BPP:       r_bpp       <= i_cfg_data[BPP_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_filter   <= FLT_NONE;
            r_first    <= 1'b1;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos    <= n_pos;
                r_filter <= n_filter;
                r_first  <= n_first;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (i_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1     <= n_s1;
            r_s1_idx <= idx;
            r_s1_sel <= SEL_W'(bpp_eff - BPW'(1));
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;
    assign o_s1_idx   = r_s1_idx;
    assign o_s1_sel   = r_s1_sel;
    assign o_rd_en    = accept && (pos != '0);
    assign o_rd_addr  = idx;

endmodule

// File: rtl/core/psu_recon.sv
// ----------------------------------------------------------------------------
// psu_recon
// Reconstruct stage: predictor, neighbor windows, write-back, output register.
// ----------------------------------------------------------------------------
module psu_recon
    import psu_pkg::*;
#(
    parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES,
    parameter int ADDR_W          = (DEF_MAX_ROW_BYTES > 1) ? $clog2(DEF_MAX_ROW_BYTES) : 1,
    parameter int SEL_W           = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s1_valid,
    input  t_s1               i_s1,
    input  logic [ADDR_W-1:0] i_s1_idx,
    input  logic [SEL_W-1:0]  i_s1_sel,
    input  logic [7:0]        i_rd_data,
    output logic              o_s1_adv,
    output logic              o_wr_en,
    output logic [ADDR_W-1:0] o_wr_addr,
    output logic [7:0]        o_wr_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_pixel_byte,
    output logic              o_row_end
);

    logic [7:0] r_left [MAX_PIXEL_BYTES];
    logic [7:0] r_upl  [MAX_PIXEL_BYTES];
    logic       r_out_valid;
    logic [7:0] r_pixel;
    logic       r_row_end;

    logic [7:0] a, b, c, pred, val;
    logic [8:0] sum_ab;
    logic       do_data;

    assign o_s1_adv = i_s1_valid && (!r_out_valid || !i_out_stall);
    assign do_data  = o_s1_adv && i_s1.is_data;

    always_comb begin
        b      = i_s1.b_en ? i_rd_data : 8'd0;
        a      = i_s1.a_en ? r_left[i_s1_sel] : 8'd0;
        c      = (i_s1.a_en && i_s1.b_en) ? r_upl[i_s1_sel] : 8'd0;
        sum_ab = {1'b0, a} + {1'b0, b};
        unique case (i_s1.filt)
            FLT_SUB:   pred = a;
            FLT_UP:    pred = b;
            FLT_AVG:   pred = sum_ab[8:1];
            FLT_PAETH: pred = paeth(a, b, c);
            default:   pred = 8'd0;
        endcase
        val = i_s1.x + pred;
    end

    // shift the newest byte in at slot zero
    always_ff @(posedge i_clk) begin
        if (do_data) begin
            r_left[0] <= val;
            r_upl[0]  <= b;
            for (int k = 1; k < MAX_PIXEL_BYTES; k++) begin
                r_left[k] <= r_left[k-1];
                r_upl[k]  <= r_upl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_data) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_data) begin
            r_pixel   <= val;
            r_row_end <= i_s1.last;
        end
    end

    assign o_wr_en      = do_data;
    assign o_wr_addr    = i_s1_idx;
    assign o_wr_data    = val;
    assign o_out_valid  = r_out_valid;
    assign o_pixel_byte = r_pixel;
    assign o_row_end    = r_row_end;

endmodule

// File: rtl/core/png_scanline_unfilter_top.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter_top
// Rebuilds PNG scanlines (None, Sub, Up, Average, Paeth) from the inflated
// byte stream, keeping the prior row in an on-chip line store.
// ----------------------------------------------------------------------------
// An accepted pixel item passes the read stage register, then the output register.
// Throughput: 1 item per cycle while not stalled; filter-type items take a slot
// but give no result. The rate is set by the registered line store read.
// Reset: synchronous, active low; clears position, row filter, first-row flag,
// valids and restores both registers to 1. The line store is not cleared.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_top
    import psu_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = DEF_MAX_ROW_BYTES,
    parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input item channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_stream_byte,
    input  logic                  i_image_start,
    // result item channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_pixel_byte,
    output logic                  o_row_end
);

    localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int SEL_W  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    // read stage: item waiting on line store data
    logic              s1_valid;
    t_s1               s1;
    logic [ADDR_W-1:0] s1_idx;
    logic [SEL_W-1:0]  s1_sel;
    logic              s1_adv;

    // line store ports
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    // Sequencer: track the byte position in the row, latch the filter from
    // each filter byte and issue the line store read for the byte above.
    psu_seq #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .ADDR_W          (ADDR_W),
        .SEL_W           (SEL_W)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_stream_byte (i_stream_byte),
        .i_image_start (i_image_start),
        .i_s1_adv      (s1_adv),
        .o_s1_valid    (s1_valid),
        .o_s1          (s1),
        .o_s1_idx      (s1_idx),
        .o_s1_sel      (s1_sel),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr)
    );

    // Line store: each entry is rewritten as its column is rebuilt. A filter
    // item always sits between two rows, so a read never meets the write of
    // the same entry in one cycle.
    psu_line_mem #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .ADDR_W        (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data)
    );

    // Reconstruct: apply the row's rule, write back, hold the result in the
    // output register while the next item is read.
    psu_recon #(
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES),
        .ADDR_W          (ADDR_W),
        .SEL_W           (SEL_W)
    ) u_recon (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s1_valid   (s1_valid),
        .i_s1         (s1),
        .i_s1_idx     (s1_idx),
        .i_s1_sel     (s1_sel),
        .i_rd_data    (rd_data),
        .o_s1_adv     (s1_adv),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_byte (o_pixel_byte),
        .o_row_end    (o_row_end)
    );

endmodule
